@@ rtl/nmcf_pkg.sv @@
// ----------------------------------------------------------------------------
// nmcf_pkg
// Shared types and constants for the 3x3 min/max clamp filter.
// ----------------------------------------------------------------------------
`default_nettype none

package nmcf_pkg;

	localparam int PIX_W   = 8;   // grey pixel width
	localparam int FW_BITS = 11;  // frame_width register width
	localparam int FH_BITS = 12;  // frame_height register width
	localparam int CFG_W   = 12;  // widest register
	localparam int ROW_W   = 13;  // row counter runs up to height + 1 while draining
	localparam int TDATA_W = 8;   // pixel, padded to whole bytes

	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;
	localparam int MIN_DIM      = 3;
	localparam int NEIGHBOURS   = 8;

	typedef enum logic [0:0] {
		CFG_FRAME_WIDTH  = 1'b0,
		CFG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef logic [PIX_W-1:0] pix_t;

endpackage

`default_nettype wire

@@ rtl/neighbour_minmax_clamp_filter.sv @@
// ----------------------------------------------------------------------------
// neighbour_minmax_clamp_filter
// 3x3 impulse filter: interior pixels are clamped to the min/max of their
// eight neighbours, border pixels pass through. Two line stores feed the window.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake          | payload
//  s_axis    | in        | tvalid / tready    | tdata[7:0] pixel_in, tuser flush
//  m_axis    | out       | tvalid / tready    | tdata[7:0] pixel_out, tlast last_of_frame
//  cfg       | in        | cfg_we (no wait)   | cfg_index register, cfg_data value
//
//  One transaction per clock sustained while m_axis_tready holds; m_axis_tvalid
//  rises once the input transaction that completes a window (one row plus one
//  pixel of input later) has passed the working stage and the result register.
//  The line stores take one read and one write per cycle; a read of the column
//  written in the same cycle is forwarded from the write data.
//  arst_n clears counters, window and valid flags; the line stores are not cleared.
//  m_axis stalls back up through the single working stage to s_axis_tready.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_minmax_clamp_filter #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire                           clk,
	input  wire                           arst_n,
	// config write port
	input  wire                           cfg_we,
	input  nmcf_pkg::cfg_reg_t            cfg_index,
	input  wire  [nmcf_pkg::CFG_W-1:0]    cfg_data,
	// input stream
	input  wire                           s_axis_tvalid,
	output logic                          s_axis_tready,
	input  wire  [nmcf_pkg::TDATA_W-1:0]  s_axis_tdata,   // [7:0] pixel_in
	input  wire                           s_axis_tuser,   // [0] flush
	// output stream
	output logic                          m_axis_tvalid,
	input  wire                           m_axis_tready,
	output logic [nmcf_pkg::TDATA_W-1:0]  m_axis_tdata,   // [7:0] pixel_out
	output logic                          m_axis_tlast    // last_of_frame
);

	import nmcf_pkg::*;

	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int WW_MAX = $clog2(MAX_WIDTH + 1);
	localparam int WW     = (WW_MAX > FW_BITS) ? WW_MAX : FW_BITS;
	localparam int RST_W  = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;

	// effective frame size, saturated at write time
	logic [WW-1:0]      width_q;
	logic [FH_BITS-1:0] height_q;
	logic [WW-1:0]      wr_width;

	// input position
	logic [AW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;

	// line stores
	pix_t               upper_mem [MAX_WIDTH];
	pix_t               middle_mem [MAX_WIDTH];
	pix_t               rd_upper_q;
	pix_t               rd_middle_q;

	// window [column: 0 oldest][row: 0 top]
	pix_t               win_q [3][3];

	// working stage
	logic               valid_s1;
	pix_t               pix_s1;
	logic [AW-1:0]      addr_s1;
	logic               emit_s1;
	logic               interior_s1;
	logic               last_s1;

	// result register
	logic               valid_s2;
	pix_t               pix_s2;
	logic               last_s2;

	logic               in_fire;
	logic               adv;
	logic               take;
	logic               drain;
	logic               emit;
	logic               interior;
	logic               last;
	logic               wrap;
	logic [WW-1:0]      col_inc;
	pix_t               pix_eff;
	logic               fwd;

	pix_t               nb [NEIGHBOURS];
	pix_t               lo;
	pix_t               hi;
	pix_t               centre;
	pix_t               result;

	// ------------------------------------------------------------------------
	// handshake
	// ------------------------------------------------------------------------
	assign adv           = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	// ------------------------------------------------------------------------
	// position decode
	// ------------------------------------------------------------------------
	always_comb begin
		drain    = row_q >= ROW_W'(height_q);
		pix_eff  = drain ? '0 : s_axis_tdata[PIX_W-1:0];
		// in-frame flush is dropped; anything during drain counts as flush
		take     = in_fire && (!s_axis_tuser || drain);
		emit     = (row_q >= ROW_W'(2)) || (row_q == ROW_W'(1) && col_q != '0);
		interior = (col_q >= AW'(2)) && (row_q >= ROW_W'(2)) && !drain;
		last     = (row_q == ROW_W'(height_q) + ROW_W'(1)) && (col_q == '0);
		col_inc  = WW'(col_q) + WW'(1);
		wrap     = col_inc == width_q;
		fwd      = valid_s1 && adv && (addr_s1 == col_q);
	end

	always_comb begin
		wr_width = WW'(cfg_data[FW_BITS-1:0]);
		if (wr_width < WW'(MIN_DIM)) begin
			wr_width = WW'(MIN_DIM);
		end else if (wr_width > WW'(MAX_WIDTH)) begin
			wr_width = WW'(MAX_WIDTH);
		end
	end

	// ------------------------------------------------------------------------
	// config and position counters
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(RST_W);
			height_q <= FH_BITS'(RESET_HEIGHT);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_FRAME_WIDTH: begin
					width_q <= wr_width;
				end
				CFG_FRAME_HEIGHT: begin
					height_q <= (cfg_data[FH_BITS-1:0] < FH_BITS'(MIN_DIM)) ?
						FH_BITS'(MIN_DIM) : cfg_data[FH_BITS-1:0];
				end
				default: begin
				end
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (take) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= AW'(col_inc);
			end
		end
	end

	// ------------------------------------------------------------------------
	// line stores: read on accept, write when the working stage moves on
	// ------------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			upper_mem[addr_s1]  <= rd_middle_q;
			middle_mem[addr_s1] <= pix_s1;
		end
		if (take) begin
			if (fwd) begin
				rd_upper_q  <= rd_middle_q;
				rd_middle_q <= pix_s1;
			end else begin
				rd_upper_q  <= upper_mem[col_q];
				rd_middle_q <= middle_mem[col_q];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pix_s1      <= pix_eff;
			addr_s1     <= col_q;
			emit_s1     <= emit;
			interior_s1 <= interior;
			last_s1     <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// clamp on the window as it stands after this shift
	// ------------------------------------------------------------------------
	always_comb begin
		nb[0]  = win_q[1][0];
		nb[1]  = win_q[1][1];
		nb[2]  = win_q[1][2];
		nb[3]  = win_q[2][0];
		nb[4]  = win_q[2][2];
		nb[5]  = rd_upper_q;
		nb[6]  = rd_middle_q;
		nb[7]  = pix_s1;
		centre = win_q[2][1];
		lo     = nb[0];
		hi     = nb[0];
		for (int k = 1; k < NEIGHBOURS; k++) begin
			if (nb[k] < lo) lo = nb[k];
			if (nb[k] > hi) hi = nb[k];
		end
		if (!interior_s1) begin
			result = centre;
		end else if (centre < lo) begin
			result = lo;
		end else if (centre > hi) begin
			result = hi;
		end else begin
			result = centre;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 3; c++) begin
				for (int r = 0; r < 3; r++) begin
					win_q[c][r] <= '0;
				end
			end
		end else if (valid_s1 && adv) begin
			for (int r = 0; r < 3; r++) begin
				win_q[0][r] <= win_q[1][r];
				win_q[1][r] <= win_q[2][r];
			end
			win_q[2][0] <= rd_upper_q;
			win_q[2][1] <= rd_middle_q;
			win_q[2][2] <= pix_s1;
		end
	end

	// ------------------------------------------------------------------------
	// result register
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (valid_s1 && adv) begin
			valid_s2 <= emit_s1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv && emit_s1) begin
			pix_s2  <= result;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = TDATA_W'(pix_s2);
	assign m_axis_tlast  = last_s2;

endmodule

`default_nettype wire

@@ rtl/nmcf_checker.sv @@
// ----------------------------------------------------------------------------
// nmcf_checker
// Port-level checks for the clamp filter, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module nmcf_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          s_axis_tvalid,
	input wire                          s_axis_tready,
	input wire                          m_axis_tvalid,
	input wire                          m_axis_tready,
	input wire [nmcf_pkg::TDATA_W-1:0]  m_axis_tdata,
	input wire                          m_axis_tlast
);

	import nmcf_pkg::*;

	// a held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("result changed while stalled");

	// input backs up only behind a stalled full result register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
		else $error("input stalled without output stall");

	// a fresh result traces back to an earlier input transaction
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
		else $error("result without matching input transaction");

	// a valid result carries known bits
	a_out_known: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tlast}))
		else $error("unknown bits on a valid result");

endmodule

bind neighbour_minmax_clamp_filter nmcf_checker u_nmcf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
